// ===== hw/rtl/hss_pkg.sv =====
package hss_pkg;

  localparam int unsigned MotorW    = 16;
  localparam int unsigned SampleW   = 8;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned CoilW     = 4;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgMotorInterval    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounceInterval = 1'd1;

  localparam logic [MotorW-1:0]  MotorIntervalRst    = 16'd50;
  localparam logic [SampleW-1:0] DebounceIntervalRst = 8'd1;

  // One tick word as seen by the button detector
  typedef struct packed {
    logic accept;
    logic level;
  } hss_tick_t;

  function automatic logic [CoilW-1:0] coil_lookup(input logic [PhaseW-1:0] phase);
    logic [CoilW-1:0] pat;
    case (phase)
      3'd0:    pat = 4'b1000;
      3'd1:    pat = 4'b1100;
      3'd2:    pat = 4'b0100;
      3'd3:    pat = 4'b0110;
      3'd4:    pat = 4'b0010;
      3'd5:    pat = 4'b0011;
      3'd6:    pat = 4'b0001;
      3'd7:    pat = 4'b1001;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

// ===== hw/rtl/hss_if.sv =====
interface hss_tick_if;
  logic valid;
  logic ready;
  logic button;

  modport source (output valid, output button, input ready);
  modport sink   (input valid, input button, output ready);
endinterface

interface hss_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] coil_pattern;
  logic [2:0] phase_index;
  logic       forward;
  logic       stepped;

  modport source (output valid, output coil_pattern, output phase_index,
                  output forward, output stepped, input ready);
  modport sink   (input valid, input coil_pattern, input phase_index,
                  input forward, input stepped, output ready);
endinterface

interface hss_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/stepper_half_step_sequencer_unit.sv =====
// Channel   Dir  Word
// tick_i    in   button level for one timer tick
// result_o  out  coil_pattern, phase_index, forward, stepped
// cfg_i     in   register index and write data
//
// One tick word is taken per clock while tick_i.ready is high; its result
// word shows in the next cycle from the output register.
// tick_i.ready is low only while a result waits and result_o.ready is low.
// Reset clears counters, phase, direction and coils; intervals return to
// 50 and 1. cfg_i is always ready.
module stepper_half_step_sequencer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  hss_tick_if.sink     tick_i,
  hss_result_if.source result_o,
  hss_cfg_if.sink      cfg_i
);
  import hss_pkg::*;

  logic [MotorW-1:0]  motor_interval_q;
  logic [SampleW-1:0] debounce_interval_q;

  logic [MotorW-1:0]  motor_elapsed_q, motor_elapsed_d;
  logic [MotorW:0]    motor_sum;
  logic               motor_fire;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [CoilW-1:0]   coil_q, coil_d;
  logic               dir_q, dir_d;
  logic               toggle;
  logic               accept;
  logic               stepped;
  hss_tick_t          tick;

  logic               out_valid_q;
  logic [CoilW-1:0]   out_coil_q;
  logic [PhaseW-1:0]  out_phase_q;
  logic               out_fwd_q;
  logic               out_step_q;

  assign tick_i.ready = !out_valid_q || result_o.ready;
  assign accept       = tick_i.valid && tick_i.ready;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_interval_q    <= MotorIntervalRst;
      debounce_interval_q <= DebounceIntervalRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgMotorInterval:    motor_interval_q    <= cfg_i.data[MotorW-1:0];
        CfgDebounceInterval: debounce_interval_q <= cfg_i.data[SampleW-1:0];
        default: ;
      endcase
    end
  end

  assign motor_sum  = {1'b0, motor_elapsed_q} + {{MotorW{1'b0}}, 1'b1};
  assign motor_fire = (motor_sum >= {1'b0, motor_interval_q});

  assign tick.accept = accept;
  assign tick.level  = tick_i.button;

  hss_debounce u_debounce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .interval_i (debounce_interval_q),
    .toggle_o   (toggle)
  );

  // step uses the direction held before this tick's button check
  always_comb begin
    motor_elapsed_d = motor_elapsed_q;
    phase_d         = phase_q;
    coil_d          = coil_q;
    dir_d           = dir_q;
    stepped         = 1'b0;
    if (accept) begin
      if (motor_fire) begin
        motor_elapsed_d = '0;
        phase_d         = dir_q ? phase_q + 3'd1 : phase_q - 3'd1;
        coil_d          = coil_lookup(phase_d);
        stepped         = 1'b1;
      end else begin
        motor_elapsed_d = motor_sum[MotorW-1:0];
      end
      dir_d = dir_q ^ toggle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_elapsed_q <= '0;
      phase_q         <= '0;
      coil_q          <= '0;
      dir_q           <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      motor_elapsed_q <= motor_elapsed_d;
      phase_q         <= phase_d;
      coil_q          <= coil_d;
      dir_q           <= dir_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_coil_q  <= coil_d;
      out_phase_q <= phase_d;
      out_fwd_q   <= dir_d;
      out_step_q  <= stepped;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.coil_pattern = out_coil_q;
  assign result_o.phase_index  = out_phase_q;
  assign result_o.forward      = out_fwd_q;
  assign result_o.stepped      = out_step_q;

endmodule

// ===== hw/rtl/hss_debounce.sv =====
module hss_debounce (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hss_pkg::hss_tick_t       tick_i,
  input  logic [hss_pkg::SampleW-1:0] interval_i,
  output logic                     toggle_o
);
  import hss_pkg::*;

  logic [SampleW-1:0] elapsed_q, elapsed_d;
  logic [SampleW:0]   sum;
  logic               fire;
  logic               prev_q, prev_d;
  logic               handled_q, handled_d;

  assign sum  = {1'b0, elapsed_q} + {{SampleW{1'b0}}, 1'b1};
  assign fire = (sum >= {1'b0, interval_i});

  always_comb begin
    elapsed_d = elapsed_q;
    prev_d    = prev_q;
    handled_d = handled_q;
    toggle_o  = 1'b0;
    if (tick_i.accept) begin
      if (fire) begin
        elapsed_d = '0;
        if (tick_i.level != prev_q) begin
          // level moved: rearm
          prev_d    = tick_i.level;
          handled_d = 1'b0;
        end else if (!handled_q) begin
          handled_d = 1'b1;
          toggle_o  = tick_i.level;
        end
      end else begin
        elapsed_d = sum[SampleW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      prev_q    <= 1'b0;
      handled_q <= 1'b0;
    end else begin
      elapsed_q <= elapsed_d;
      prev_q    <= prev_d;
      handled_q <= handled_d;
    end
  end

endmodule

// ===== hw/rtl/hss_checker.sv =====
module hss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tick_valid_i,
  input logic       tick_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [3:0] res_coil_i,
  input logic [2:0] res_phase_i,
  input logic       res_stepped_i
);
  import hss_pkg::*;

  // a step always leaves the coils on the table entry for the new phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_stepped_i) |-> (res_coil_i == coil_lookup(res_phase_i)))
    else $error("coil pattern does not match stepped phase");

  // every taken tick produces a word on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid_i && tick_ready_i) |=> res_valid_i)
    else $error("tick taken without a result word");

  // an empty output register never blocks ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> tick_ready_i)
    else $error("tick stalled with no pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result word dropped while stalled");

endmodule

bind stepper_half_step_sequencer_unit hss_checker u_hss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .tick_valid_i  (tick_i.valid),
  .tick_ready_i  (tick_i.ready),
  .res_valid_i   (result_o.valid),
  .res_ready_i   (result_o.ready),
  .res_coil_i    (result_o.coil_pattern),
  .res_phase_i   (result_o.phase_index),
  .res_stepped_i (result_o.stepped)
);
